// File: hw/rtl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int DIST_W = 19;
	localparam logic [DIST_W-1:0] DIST_MAX = 19'h7FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIG_LOW  = 8'd0,
		CFG_TRIG_HIGH = 8'd1,
		CFG_TIMEOUT   = 8'd2,
		CFG_SCALE     = 8'd3
	} cfg_idx_t;

	localparam logic [7:0]  TRIG_LOW_RST  = 8'd2;
	localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
	localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
	localparam logic [15:0] SCALE_RST     = 16'd1124;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TRIG_LOW  = 3'd1,
		PH_TRIG_HIGH = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_MEASURE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]  trig_low;
		logic [7:0]  trig_high;
		logic [15:0] timeout;
	} timing_cfg_t;

	typedef struct packed {
		logic trig;
		logic busy;
		logic done;
		logic tmo;
		logic meas_end;
	} step_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/uer_ifs.sv
// Valid/ready channel interfaces: tick input, result output, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface uer_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic echo_level;

	modport source (output valid, output start_req, output echo_level, input ready);
	modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if;
	logic                      valid;
	logic                      ready;
	logic                      trig_level;
	logic                      busy_res;
	logic                      done_res;
	logic                      timed_out;
	logic [uer_pkg::DIST_W-1:0] distance_q8;

	modport source (output valid, output trig_level, output busy_res, output done_res,
		output timed_out, output distance_q8, input ready);
	modport sink (input valid, input trig_level, input busy_res, input done_res,
		input timed_out, input distance_q8, output ready);
endinterface

interface uer_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [uer_pkg::CFG_IDX_W-1:0]  index;
	logic [uer_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: registers, tick pipeline and distance scaling.
//
// item_in carries one word per microsecond tick: start_req and the sampled
// echo_level. Every accepted word yields exactly one word on res_out with the
// trigger level, busy, done, timeout flag and the distance in cm (Q8), in
// the order the ticks were taken.
// cfg writes the timing registers (0 trig_low_us, 1 trig_high_us,
// 2 timeout_us, 3 scale_q16); it is always ready, other indices are dropped.
// Two registered stages lie between acceptance and res_out. Stage 1 holds the
// sequencer step, stage 2 holds the 16-bit scale multiply with rounding
// and saturation. Throughput: one word per cycle while res_out is not stalled.
// When res_out stalls, the two stages fill and item_in.ready falls; it
// rises again in the cycle the receiver takes a word.
// Reset puts the sequencer in idle with cleared counters, restores the
// register defaults and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_unit #(
	parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	uer_in_if.sink     item_in,
	uer_out_if.source  res_out,
	uer_cfg_if.sink    cfg
);

	localparam int PROD_W = TIMER_BITS + 16;
	localparam int SH_W   = PROD_W + 1 - 8;
	localparam int CMPD_W = (SH_W > uer_pkg::DIST_W) ? SH_W : uer_pkg::DIST_W;

	logic [7:0]  trig_low_q, trig_high_q;
	logic [15:0] timeout_q, scale_q;

	uer_pkg::timing_cfg_t   tcfg;
	uer_pkg::step_res_t     step_res;
	logic [TIMER_BITS-1:0]  pw_cur;
	logic                   accept, adv_s1;

	logic                   valid_s1;
	uer_pkg::step_res_t     res_s1;
	logic [TIMER_BITS-1:0]  pw_s1;
	logic [15:0]            scale_s1;

	logic [PROD_W-1:0]          prod;
	logic [PROD_W:0]            rnd;
	logic [CMPD_W-1:0]          shifted;
	logic [uer_pkg::DIST_W-1:0] dist_sat;

	logic                       valid_q;
	logic                       trig_q, busy_q, done_q, tmo_q;
	logic [uer_pkg::DIST_W-1:0] dist_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_low_q  <= uer_pkg::TRIG_LOW_RST;
			trig_high_q <= uer_pkg::TRIG_HIGH_RST;
			timeout_q   <= uer_pkg::TIMEOUT_RST;
			scale_q     <= uer_pkg::SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				uer_pkg::CFG_TRIG_LOW:  trig_low_q  <= cfg.data[7:0];
				uer_pkg::CFG_TRIG_HIGH: trig_high_q <= cfg.data[7:0];
				uer_pkg::CFG_TIMEOUT:   timeout_q   <= cfg.data;
				uer_pkg::CFG_SCALE:     scale_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign tcfg = '{trig_low: trig_low_q, trig_high: trig_high_q, timeout: timeout_q};

	// handshake: stage 1 advances when the output register is free or draining
	assign adv_s1        = !valid_q || res_out.ready;
	assign item_in.ready = !valid_s1 || adv_s1;
	assign accept        = item_in.valid && item_in.ready;

	uer_ctrl #(
		.TIMER_BITS (TIMER_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.start_req   (item_in.start_req),
		.echo_level  (item_in.echo_level),
		.cfg         (tcfg),
		.res         (step_res),
		.pulse_width (pw_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	// hold the stage payload while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1   <= step_res;
			pw_s1    <= pw_cur;
			scale_s1 <= scale_q;
		end
	end

	// distance: (width * scale + 128) >> 8, saturated
	assign prod     = PROD_W'(pw_s1) * PROD_W'(scale_s1);
	assign rnd      = {1'b0, prod} + (PROD_W+1)'(128);
	assign shifted  = CMPD_W'(rnd[PROD_W:8]);
	assign dist_sat = (shifted > CMPD_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX :
		uer_pkg::DIST_W'(shifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_s1) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			trig_q <= res_s1.trig;
			busy_q <= res_s1.busy;
			done_q <= res_s1.done;
			tmo_q  <= res_s1.tmo;
			dist_q <= res_s1.meas_end ? dist_sat : '0;
		end
	end

	assign res_out.valid       = valid_q;
	assign res_out.trig_level  = trig_q;
	assign res_out.busy_res    = busy_q;
	assign res_out.done_res    = done_q;
	assign res_out.timed_out   = tmo_q;
	assign res_out.distance_q8 = dist_q;

endmodule

`default_nettype wire

// File: hw/rtl/uer_ctrl.sv
// Trigger/echo sequencer: phase, phase timer and pulse width, one step per tick.
`timescale 1ns / 1ps
`default_nettype none

module uer_ctrl #(
	parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       step,
	input  wire                       start_req,
	input  wire                       echo_level,
	input  wire uer_pkg::timing_cfg_t cfg,
	output uer_pkg::step_res_t        res,
	output logic [TIMER_BITS-1:0]     pulse_width
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	uer_pkg::phase_t        phase_q, phase_nxt;
	logic [TIMER_BITS-1:0]  timer_q, timer_nxt;
	logic [TIMER_BITS-1:0]  pw_q, pw_nxt;
	logic [TIMER_BITS-1:0]  timer_inc;
	logic [CMP_W-1:0]       timeout_ext, timer_max, limit;

	// clamp the timeout to what the counters can hold
	assign timeout_ext = CMP_W'(cfg.timeout);
	assign timer_max   = CMP_W'({TIMER_BITS{1'b1}});
	assign limit       = (timeout_ext < timer_max) ? timeout_ext : timer_max;
	assign timer_inc   = timer_q + 1'b1;

	always_comb begin
		phase_nxt = phase_q;
		timer_nxt = timer_q;
		pw_nxt    = pw_q;
		case (phase_q)
			uer_pkg::PH_TRIG_LOW: begin
				if (CMP_W'(timer_inc) >= CMP_W'(cfg.trig_low)) begin
					phase_nxt = uer_pkg::PH_TRIG_HIGH;
					timer_nxt = '0;
				end else begin
					timer_nxt = timer_inc;
				end
			end
			uer_pkg::PH_TRIG_HIGH: begin
				if (CMP_W'(timer_inc) >= CMP_W'(cfg.trig_high)) begin
					phase_nxt = uer_pkg::PH_WAIT_RISE;
					timer_nxt = '0;
				end else begin
					timer_nxt = timer_inc;
				end
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (echo_level) begin
					phase_nxt = uer_pkg::PH_MEASURE;
					pw_nxt    = TIMER_BITS'(1);
					timer_nxt = '0;
				end else if (CMP_W'(timer_q) >= limit) begin
					phase_nxt = uer_pkg::PH_IDLE;
					timer_nxt = '0;
				end else begin
					timer_nxt = timer_inc;
				end
			end
			uer_pkg::PH_MEASURE: begin
				if (echo_level) begin
					if (CMP_W'(pw_q) >= limit) begin
						phase_nxt = uer_pkg::PH_IDLE;
						pw_nxt    = '0;
					end else begin
						pw_nxt = pw_q + 1'b1;
					end
				end else begin
					phase_nxt = uer_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_nxt = uer_pkg::PH_IDLE;
				if (start_req) begin
					phase_nxt = uer_pkg::PH_TRIG_LOW;
					timer_nxt = '0;
					pw_nxt    = '0;
				end
			end
		endcase
	end

	always_comb begin
		res = '{trig: 1'b0, busy: 1'b1, done: 1'b0, tmo: 1'b0, meas_end: 1'b0};
		case (phase_q)
			uer_pkg::PH_TRIG_LOW: begin
			end
			uer_pkg::PH_TRIG_HIGH: begin
				res.trig = 1'b1;
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (!echo_level && CMP_W'(timer_q) >= limit) begin
					res.busy = 1'b0;
					res.done = 1'b1;
					res.tmo  = 1'b1;
				end
			end
			uer_pkg::PH_MEASURE: begin
				if (echo_level) begin
					if (CMP_W'(pw_q) >= limit) begin
						res.busy = 1'b0;
						res.done = 1'b1;
						res.tmo  = 1'b1;
					end
				end else begin
					res.busy     = 1'b0;
					res.done     = 1'b1;
					res.meas_end = 1'b1;
				end
			end
			default: begin
				res.busy = 1'b0;
			end
		endcase
	end

	assign pulse_width = pw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			timer_q <= '0;
			pw_q    <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			timer_q <= timer_nxt;
			pw_q    <= pw_nxt;
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the ultrasonic echo ranger: random-paced ticks against a predictor.
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic                       trig;
		logic                       busy;
		logic                       done;
		logic                       tmo;
		logic [uer_pkg::DIST_W-1:0] distance;
	} ranger_word_t;

	localparam logic [uer_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFC;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	uer_in_if  tick_ch ();
	uer_out_if res_ch ();
	uer_cfg_if cfg_ch ();

	ultrasonic_echo_ranger_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (tick_ch),
		.res_out (res_ch),
		.cfg     (cfg_ch)
	);

	// predictor registers and sequencer state
	logic [7:0]      m_trig_low;
	logic [7:0]      m_trig_high;
	logic [15:0]     m_timeout;
	logic [15:0]     m_scale;
	uer_pkg::phase_t m_phase;
	logic [15:0]     m_timer;
	logic [15:0]     m_width;

	ranger_word_t echo_reports[$];
	int unsigned  mismatches = 0;
	int unsigned  ticks_sent = 0;
	bit           in_idle_on = 1'b1;
	bit           out_idle_on = 1'b1;

	function automatic ranger_word_t step_ranger(input bit start, input bit echo);
		ranger_word_t w;
		logic [32:0]  prod;
		w = '0;
		w.busy = 1'b1;
		case (m_phase)
			uer_pkg::PH_TRIG_LOW: begin
				m_timer = m_timer + 16'd1;
				if (m_timer >= 16'(m_trig_low)) begin
					m_phase = uer_pkg::PH_TRIG_HIGH;
					m_timer = '0;
				end
			end
			uer_pkg::PH_TRIG_HIGH: begin
				w.trig = 1'b1;
				m_timer = m_timer + 16'd1;
				if (m_timer >= 16'(m_trig_high)) begin
					m_phase = uer_pkg::PH_WAIT_RISE;
					m_timer = '0;
				end
			end
			uer_pkg::PH_WAIT_RISE: begin
				if (echo) begin
					m_phase = uer_pkg::PH_MEASURE;
					m_width = 16'd1;
					m_timer = '0;
				end else if (m_timer >= m_timeout) begin
					w.busy = 1'b0;
					w.done = 1'b1;
					w.tmo = 1'b1;
					m_phase = uer_pkg::PH_IDLE;
					m_timer = '0;
				end else begin
					m_timer = m_timer + 16'd1;
				end
			end
			uer_pkg::PH_MEASURE: begin
				if (echo) begin
					if (m_width >= m_timeout) begin
						w.busy = 1'b0;
						w.done = 1'b1;
						w.tmo = 1'b1;
						m_phase = uer_pkg::PH_IDLE;
						m_width = '0;
					end else begin
						m_width = m_width + 16'd1;
					end
				end else begin
					// round half up, then clip to the distance range
					prod = (33'(m_width) * 33'(m_scale) + 33'd128) >> 8;
					w.distance = (prod > 33'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX :
						prod[uer_pkg::DIST_W-1:0];
					w.busy = 1'b0;
					w.done = 1'b1;
					m_phase = uer_pkg::PH_IDLE;
				end
			end
			default: begin
				w.busy = 1'b0;
				m_phase = uer_pkg::PH_IDLE;
				if (start) begin
					m_phase = uer_pkg::PH_TRIG_LOW;
					m_timer = '0;
					m_width = '0;
				end
			end
		endcase
		return w;
	endfunction

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_tick(input bit start, input bit echo);
		int unsigned gap;
		gap = in_idle_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.start_req <= start;
		tick_ch.echo_level <= echo;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		echo_reports.push_back(step_ranger(start, echo));
		ticks_sent++;
		@(negedge clk);
	endtask

	// Drop valid and let the pipeline empty.
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (echo_reports.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
		input logic [uer_pkg::CFG_DATA_W-1:0] value);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			uer_pkg::CFG_TRIG_LOW:  m_trig_low = value[7:0];
			uer_pkg::CFG_TRIG_HIGH: m_trig_high = value[7:0];
			uer_pkg::CFG_TIMEOUT:   m_timeout = value;
			uer_pkg::CFG_SCALE:     m_scale = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Start, trigger ticks, echo low for rise ticks, high for width ticks, then low.
	task automatic run_measure(input int rise, input int width, input int tail, input bit noisy);
		int n;
		n = (m_trig_low == 0 ? 1 : m_trig_low) + (m_trig_high == 0 ? 1 : m_trig_high);
		send_tick(1'b1, noisy && $urandom_range(0, 1) == 1);
		repeat (n) send_tick(noisy && $urandom_range(0, 7) == 0, noisy && $urandom_range(0, 1) == 1);
		repeat (rise) send_tick(noisy && $urandom_range(0, 7) == 0, 1'b0);
		repeat (width) send_tick(noisy && $urandom_range(0, 7) == 0, 1'b1);
		repeat (tail) send_tick(1'b0, 1'b0);
	endtask

	task automatic test_defaults();
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		run_measure(3, 12, 2, 1'b0);
		// hold start high through a whole measurement: it must be ignored while busy
		repeat (13) send_tick(1'b1, 1'b1);
		repeat (2) send_tick(1'b1, 1'b0);
		repeat (5) send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic test_zero_trigger();
		write_reg(uer_pkg::CFG_TRIG_LOW, 16'd0);
		write_reg(uer_pkg::CFG_TRIG_HIGH, 16'd0);
		run_measure(0, 1, 1, 1'b0);
		run_measure(2, 4, 1, 1'b0);
	endtask

	task automatic test_timeouts();
		write_reg(uer_pkg::CFG_TIMEOUT, 16'd0);
		run_measure(1, 0, 2, 1'b0);
		run_measure(0, 3, 2, 1'b0);
		write_reg(uer_pkg::CFG_TIMEOUT, 16'd1);
		run_measure(2, 0, 1, 1'b0);
		run_measure(1, 1, 1, 1'b0);
		run_measure(0, 3, 1, 1'b0);
	endtask

	task automatic test_extremes();
		write_reg(uer_pkg::CFG_TRIG_LOW, 16'd1);
		write_reg(uer_pkg::CFG_TRIG_HIGH, 16'd1);
		write_reg(uer_pkg::CFG_TIMEOUT, 16'hFFFF);
		write_reg(uer_pkg::CFG_SCALE, 16'hFFFF);
		run_measure(1, 1, 1, 1'b0);
		run_measure(0, 60, 1, 1'b0);
		write_reg(uer_pkg::CFG_SCALE, 16'd0);
		run_measure(0, 5, 1, 1'b0);
	endtask

	task automatic test_register_decode();
		write_reg(uer_pkg::CFG_SCALE, 16'h5A5A);
		write_reg(CFG_IDX_UNUSED, 16'hFFFF);
		run_measure(1, 7, 1, 1'b0);
	endtask

	task automatic test_random();
		logic [15:0] val;
		int unsigned stop_at;
		repeat (3) begin
			val = 16'($urandom_range(0, 65535));
			val[7:0] = 8'($urandom_range(0, 6));
			write_reg(uer_pkg::CFG_TRIG_LOW, val);
			val = 16'($urandom_range(0, 65535));
			val[7:0] = 8'($urandom_range(0, 12));
			write_reg(uer_pkg::CFG_TRIG_HIGH, val);
			write_reg(uer_pkg::CFG_TIMEOUT, 16'($urandom_range(0, 40)));
			write_reg(uer_pkg::CFG_SCALE, 16'($urandom_range(0, 65535)));
			in_idle_on = $urandom_range(0, 2) != 0;
			out_idle_on = $urandom_range(0, 2) != 0;
			stop_at = ticks_sent + 50;
			while (ticks_sent < stop_at) begin
				if ($urandom_range(0, 3) != 0)
					run_measure($urandom_range(0, m_timeout + 2), $urandom_range(1, m_timeout + 2),
						$urandom_range(1, 3), 1'b1);
				else
					repeat ($urandom_range(1, 10))
						send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
			end
		end
	endtask

	initial begin
		tick_ch.valid <= 1'b0;
		tick_ch.start_req <= 1'b0;
		tick_ch.echo_level <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		m_trig_low = uer_pkg::TRIG_LOW_RST;
		m_trig_high = uer_pkg::TRIG_HIGH_RST;
		m_timeout = uer_pkg::TIMEOUT_RST;
		m_scale = uer_pkg::SCALE_RST;
		m_phase = uer_pkg::PH_IDLE;
		m_timer = '0;
		m_width = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults();
		test_zero_trigger();
		test_timeouts();
		test_extremes();
		test_register_decode();
		test_random();
		settle();
		if (mismatches == 0)
			$display("[ultrasonic_echo_ranger_unit] OK");
		else
			$display("[ultrasonic_echo_ranger_unit] ERROR");
		$finish;
	end

	// result side: random stalls, compare every word with the oldest prediction
	initial begin
		ranger_word_t want;
		int unsigned  stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = out_idle_on ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			if (echo_reports.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none, got %0b %0b %0b %0b %0d",
					$time, res_ch.trig_level, res_ch.busy_res, res_ch.done_res,
					res_ch.timed_out, res_ch.distance_q8);
			end else begin
				want = echo_reports.pop_front();
				report("trig_level", want.trig, res_ch.trig_level);
				report("busy_res", want.busy, res_ch.busy_res);
				report("done_res", want.done, res_ch.done_res);
				report("timed_out", want.tmo, res_ch.timed_out);
				report("distance_q8", want.distance, res_ch.distance_q8);
			end
			@(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("[ultrasonic_echo_ranger_unit] ERROR");
		$finish;
	end

endmodule
